### hw/rtl/jbcd_pkg.sv
// ----------------------------------------------------------------------------
// JPEG block coefficient decoder package
// Shared types, constants and the magnitude decoding function.
// ----------------------------------------------------------------------------
package jbcd_pkg;

   localparam int SYMBOL_WIDTH    = 8;
   localparam int MAGNITUDE_WIDTH = 15;
   localparam int POSITION_WIDTH  = 6;
   localparam int COEF_WIDTH      = 16;
   localparam int REQ_DATA_WIDTH  = 24;
   localparam int RSP_DATA_WIDTH  = 24;

   localparam logic [POSITION_WIDTH-1:0] LAST_POSITION = 6'd63;
   localparam logic [3:0]                ZRL_RUN       = 4'd15;

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_EMIT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;   // take the accepted symbol and plan its results
      logic emit;   // move the current result into the output register
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_free;    // output register can take a result this cycle
      logic final_res;   // the current result is the symbol's last one
   } status_type;

   // Size 1..15: a value whose top bit is clear is negative, b - (2^s - 1).
   function automatic logic [COEF_WIDTH-1:0] decode_magnitude(
      input logic [MAGNITUDE_WIDTH-1:0] bits,
      input logic [3:0]                 size
   );
      logic [COEF_WIDTH-1:0] mask;
      logic [COEF_WIDTH-1:0] b;
      logic [COEF_WIDTH-1:0] result;
      mask = (COEF_WIDTH'(1) << size) - COEF_WIDTH'(1);
      b    = {1'b0, bits} & mask;
      if (size == 4'd0) begin
         result = '0;
      end else if (bits[size - 4'd1]) begin
         result = b;
      end else begin
         result = b - mask;
      end
      return result;
   endfunction

endpackage

### hw/rtl/jbcd_ctrl.sv
// ----------------------------------------------------------------------------
// JPEG block coefficient decoder controller
// Accepts one symbol, then steps the datapath through its results.
// ----------------------------------------------------------------------------
module jbcd_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  jbcd_pkg::status_type status,
   output jbcd_pkg::cmd_type    cmd
);
   import jbcd_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.out_free && status.final_res) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         ST_EMIT: begin
            cmd.emit = status.out_free;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

`ifndef NO_ASSERTIONS
   // A symbol is never loaded while results of the previous one are pending.
   a_no_load_in_emit: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT |-> !cmd.load)
      else $error("symbol loaded while emitting");
   // After a load the controller always starts emitting.
   a_load_starts_emit: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff == ST_EMIT)
      else $error("load not followed by emission");
   // Leaving the emit state only happens on the final result.
   a_leave_on_final: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT && !(status.out_free && status.final_res) |=> state_ff == ST_EMIT)
      else $error("emission ended early");
`endif

endmodule

### hw/rtl/jbcd_datapath.sv
// ----------------------------------------------------------------------------
// JPEG block coefficient decoder datapath
// Plans the results of one symbol, holds the block position, the DC
// predictor and the output register.
// ----------------------------------------------------------------------------
module jbcd_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic [jbcd_pkg::REQ_DATA_WIDTH-1:0]   req_tdata,
   input  logic                                  req_tuser,
   input  jbcd_pkg::cmd_type                      cmd,
   output jbcd_pkg::status_type                   status,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [jbcd_pkg::RSP_DATA_WIDTH-1:0]   rsp_tdata,
   output logic                                  rsp_tuser,
   output logic                                  rsp_tlast
);
   import jbcd_pkg::*;

   // Block state: position 0 means a DC symbol is expected.
   logic [POSITION_WIDTH-1:0] next_pos_ff, next_pos_in;
   logic [COEF_WIDTH-1:0]     pred_ff, pred_in;

   // Plan of the symbol being emitted.
   logic [POSITION_WIDTH-1:0] cur_ff, cur_in;
   logic [POSITION_WIDTH-1:0] end_ff, end_in;
   logic [COEF_WIDTH-1:0]     end_coef_ff, end_coef_in;
   logic                      err_ff, err_in;

   // Output register.
   logic                      rsp_valid_ff;
   logic [POSITION_WIDTH-1:0] rsp_pos_ff;
   logic [COEF_WIDTH-1:0]     rsp_coef_ff;
   logic                      rsp_err_ff;
   logic                      rsp_last_ff;

   logic [SYMBOL_WIDTH-1:0]    symbol;
   logic [MAGNITUDE_WIDTH-1:0] magnitude_bits;
   logic [3:0]                 run;
   logic [3:0]                 size;
   logic [COEF_WIDTH-1:0]      value;
   logic [COEF_WIDTH-1:0]      pred_sum;
   logic [POSITION_WIDTH:0]    run_end;
   logic [POSITION_WIDTH:0]    zrl_end;

   assign symbol         = req_tdata[SYMBOL_WIDTH-1:0];
   assign magnitude_bits = req_tdata[SYMBOL_WIDTH+MAGNITUDE_WIDTH-1:SYMBOL_WIDTH];
   assign run            = symbol[7:4];
   assign size           = symbol[3:0];
   assign value          = decode_magnitude(magnitude_bits, size);
   assign pred_sum       = (req_tuser ? '0 : pred_ff) + value;
   assign run_end        = {1'b0, next_pos_ff} + {3'b000, run};
   assign zrl_end        = {1'b0, next_pos_ff} + {3'b000, ZRL_RUN};

   always_comb begin
      pred_in     = pred_ff;
      next_pos_in = next_pos_ff;
      cur_in      = next_pos_ff;
      end_in      = LAST_POSITION;
      end_coef_in = '0;
      err_in      = 1'b0;
      priority if (next_pos_ff == '0) begin
         pred_in     = pred_sum;
         cur_in      = '0;
         end_in      = '0;
         end_coef_in = pred_sum;
         next_pos_in = POSITION_WIDTH'(1);
      end else if (size == 4'd0) begin
         // ZRL gives sixteen zeros clipped at the block end; anything else is EOB.
         if (run == ZRL_RUN && zrl_end < {1'b0, LAST_POSITION}) begin
            end_in = zrl_end[POSITION_WIDTH-1:0];
         end
         next_pos_in = (end_in == LAST_POSITION) ? '0 : end_in + POSITION_WIDTH'(1);
      end else if (run_end > {1'b0, LAST_POSITION}) begin
         err_in      = 1'b1;
         cur_in      = '0;
         end_in      = '0;
         next_pos_in = '0;
      end else begin
         end_in      = run_end[POSITION_WIDTH-1:0];
         end_coef_in = value;
         next_pos_in = (end_in == LAST_POSITION) ? '0 : end_in + POSITION_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_pos_ff <= '0;
         pred_ff     <= '0;
      end else if (cmd.load) begin
         next_pos_ff <= next_pos_in;
         pred_ff     <= pred_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cur_ff      <= cur_in;
         end_ff      <= end_in;
         end_coef_ff <= end_coef_in;
         err_ff      <= err_in;
      end else if (cmd.emit) begin
         cur_ff <= cur_ff + POSITION_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_pos_ff  <= err_ff ? '0 : cur_ff;
         rsp_coef_ff <= (cur_ff == end_ff) ? end_coef_ff : '0;
         rsp_err_ff  <= err_ff;
         rsp_last_ff <= err_ff || (cur_ff == LAST_POSITION);
      end
   end

   assign status.out_free  = !rsp_valid_ff || rsp_tready;
   assign status.final_res = err_ff || (cur_ff == end_ff);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_WIDTH-POSITION_WIDTH-COEF_WIDTH){1'b0}},
                        rsp_coef_ff, rsp_pos_ff};
   assign rsp_tuser  = rsp_err_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef NO_ASSERTIONS
   // An error transfer ends the block and carries position zero.
   a_err_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_err_ff |-> rsp_last_ff && rsp_pos_ff == '0 && rsp_coef_ff == '0)
      else $error("malformed error result");
   // A result that is not the symbol's final one never lies past the end.
   a_cur_before_end: assert property (@(posedge clock) disable iff (reset)
      cmd.emit && !err_ff && cur_ff != end_ff |-> cur_ff < end_ff)
      else $error("run walked past its end position");
   // Emitting a result at the last position leaves a block end flagged.
   a_last_at_end: assert property (@(posedge clock) disable iff (reset)
      cmd.emit && cur_ff == LAST_POSITION |=> rsp_last_ff)
      else $error("position 63 not flagged last");
`endif

endmodule

### hw/rtl/jpeg_block_coefficient_decoder.sv
// ----------------------------------------------------------------------------
// JPEG block coefficient decoder
// Turns decoded Huffman symbols of a baseline block into zig-zag coefficients.
// ----------------------------------------------------------------------------
// A symbol is taken in one transfer, after which its results leave one per
// cycle while the result side does not stall: the symbol is first planned,
// then each of its results goes through the output register, and no new
// symbol is taken until its last result has entered that register. The first
// symbol of each block is DC and updates a 16-bit wrapping predictor; an AC
// run past position 63 yields a single result with tuser (error) and tlast
// set, and the next symbol is taken as DC.
module jpeg_block_coefficient_decoder (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [7:0] symbol, [22:8] magnitude_bits, [23] zero
   input  logic [jbcd_pkg::REQ_DATA_WIDTH-1:0] req_tdata,
   // [0] clear_prediction
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [5:0] position, [21:6] coefficient, [23:22] zero
   output logic [jbcd_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata,
   // [0] error
   output logic                                rsp_tuser,
   output logic                                rsp_tlast
);
   import jbcd_pkg::*;

   cmd_type    cmd;
   status_type status;

   jbcd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   jbcd_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

### tb/jpeg_block_coefficient_decoder_tb.sv
// ----------------------------------------------------------------------------
// JPEG block coefficient decoder testbench
// Sends Huffman symbols of baseline blocks with random gaps and result-side
// stalls, predicts the zig-zag coefficients of every accepted symbol and
// compares each result transfer field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module jpeg_block_coefficient_decoder_tb;

   timeunit 1ns;
   timeprecision 1ps;

   import jbcd_pkg::*;

   localparam int RANDOM_SYMBOLS = 450;
   localparam int HOLD_CYCLES    = 400;
   localparam int DRAIN_CYCLES   = 80;
   localparam int CYCLE_LIMIT    = 5000000;
   localparam int REPORT_LIMIT   = 100;
   localparam int BLOCK_END      = 63;

   typedef struct packed {
      logic [POSITION_WIDTH-1:0]    position;
      logic signed [COEF_WIDTH-1:0] coefficient;
      logic                         error;
      logic                         last;
   } coef_result_type;

   // Keeps its own block position and DC predictor, and the coefficients
   // still owed by the block.
   class coefficient_scoreboard;
      coef_result_type owed_q[$];
      logic [6:0]      next_pos;
      logic [15:0]     dc_pred;
      int unsigned     failures;
      int unsigned     reports;

      function new();
         next_pos = '0;
         dc_pred  = '0;
         failures = 0;
         reports  = 0;
      endfunction

      function int pending();
         return owed_q.size();
      endfunction

      // Values whose top bit is clear are negative: b - (2^size - 1).
      function logic [15:0] magnitude_value(logic [14:0] bits, logic [3:0] size);
         int span;
         int b;
         if (size == 4'd0) return '0;
         span = (1 << size) - 1;
         b    = int'(bits) & span;
         if (b >= (1 << (size - 1))) return 16'(b);
         return 16'(b - span);
      endfunction

      function void owe(int pos, logic [15:0] coef, logic err, logic last);
         coef_result_type r;
         r.position    = POSITION_WIDTH'(pos);
         r.coefficient = coef;
         r.error       = err;
         r.last        = last;
         owed_q.push_back(r);
      endfunction

      function void note_symbol(logic [7:0] sym, logic [14:0] bits, logic clr);
         logic [3:0] run_len;
         logic [3:0] size;
         int         k;
         int         stop;
         run_len = sym[7:4];
         size    = sym[3:0];
         k       = int'(next_pos);
         if (k == 0 || k > BLOCK_END) begin
            if (clr) dc_pred = '0;
            dc_pred  = dc_pred + magnitude_value(bits, size);
            owe(0, dc_pred, 1'b0, 1'b0);
            next_pos = 7'd1;
         end else if (size == 4'd0) begin
            // EOB and every other zero-size form fill to the end; ZRL stops
            // after sixteen zeros unless that would pass the last position.
            stop = BLOCK_END;
            if (run_len == ZRL_RUN && k + 15 < BLOCK_END) stop = k + 15;
            while (k <= stop) begin
               owe(k, '0, 1'b0, k == BLOCK_END);
               k++;
            end
            next_pos = (k > BLOCK_END) ? 7'd0 : 7'(k);
         end else if (k + run_len > BLOCK_END) begin
            owe(0, '0, 1'b1, 1'b1);
            next_pos = '0;
         end else begin
            repeat (run_len) begin
               owe(k, '0, 1'b0, 1'b0);
               k++;
            end
            owe(k, magnitude_value(bits, size), 1'b0, k == BLOCK_END);
            k++;
            next_pos = (k > BLOCK_END) ? 7'd0 : 7'(k);
         end
      endfunction

      function void report(string what, int want, int got);
         failures++;
         if (reports < REPORT_LIMIT) begin
            reports++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
         end
      endfunction

      function void check_coefficient(logic [5:0] pos, logic [15:0] coef, logic err,
                                      logic last);
         coef_result_type want;
         if (owed_q.size() == 0) begin
            report("unexpected result, position", -1, int'(pos));
            return;
         end
         want = owed_q.pop_front();
         if (want.position !== pos) report("position", want.position, pos);
         if (want.coefficient !== coef)
            report("coefficient", want.coefficient, $signed(coef));
         if (want.error !== err) report("error", want.error, err);
         if (want.last !== last) report("last", want.last, last);
      endfunction
   endclass

   logic                      clock      = 1'b0;
   logic                      reset      = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_DATA_WIDTH-1:0] req_tdata  = '0;
   logic                      req_tuser  = 1'b0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_DATA_WIDTH-1:0] rsp_tdata;
   logic                      rsp_tuser;
   logic                      rsp_tlast;

   coefficient_scoreboard sb = new();

   bit          req_gaps     = 1'b0;
   bit          rsp_stalls   = 1'b0;
   bit          hold_request = 1'b0;
   int unsigned symbols_sent = 0;
   int unsigned cycles       = 0;

   jpeg_block_coefficient_decoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("jpeg_block_coefficient_decoder_tb: FAIL");
         $finish;
      end
   end

   // Both channels are observed at the rising edge only.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            sb.note_symbol(req_tdata[7:0], req_tdata[22:8], req_tuser);
         if (rsp_tvalid && rsp_tready)
            sb.check_coefficient(rsp_tdata[5:0], rsp_tdata[21:6], rsp_tuser, rsp_tlast);
      end
   end

   // Result side: short stalls mostly, now and then a long one, and a single
   // long hold-off on request so that the block backs up onto its input.
   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            stall_left   = HOLD_CYCLES;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (rsp_stalls && $urandom_range(0, 4) == 0) begin
            stall_left = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40)
                                                       : $urandom_range(0, 2);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   function automatic int idle_gap();
      int r;
      if (!req_gaps) return 0;
      r = $urandom_range(0, 9);
      if (r < 6) return 0;
      if (r < 9) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   task automatic send_symbol(input logic [7:0] sym, input logic [14:0] bits,
                              input logic clr);
      int gap;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, bits, sym};
      req_tuser  <= clr;
      do @(posedge clock); while (!req_tready);
      symbols_sent++;
      gap = idle_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         req_tdata  <= REQ_DATA_WIDTH'($urandom);
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // Block position once a symbol has been taken at position k; 0 when the
   // block is over and the next symbol is DC.
   function automatic int position_after(int k, logic [7:0] sym);
      int run_len;
      run_len = int'(sym[7:4]);
      if (sym[3:0] == 4'd0)
         return (sym[7:4] == ZRL_RUN && k + 15 < BLOCK_END) ? k + 16 : 0;
      if (k + run_len >= BLOCK_END) return 0;
      return k + run_len + 1;
   endfunction

   task automatic send_random_block();
      int         k;
      int         r;
      logic [7:0] sym;
      logic [3:0] run_len;
      logic [3:0] size;
      size = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(12, 15))
                                         : 4'($urandom_range(0, 11));
      send_symbol({4'($urandom), size}, 15'($urandom), $urandom_range(0, 7) == 0);
      k = 1;
      while (k != 0) begin
         r = $urandom_range(0, 99);
         if (r < 5 || (k > 40 && r < 15)) begin
            sym = {4'($urandom_range(0, 14)), 4'd0};
         end else if (r < 11) begin
            sym = {ZRL_RUN, 4'd0};
         end else if (r < 15) begin
            sym = 8'($urandom);
         end else begin
            run_len = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                                  : 4'($urandom_range(0, 2));
            size    = ($urandom_range(0, 5) == 0) ? 4'($urandom_range(11, 15))
                                                  : 4'($urandom_range(1, 10));
            sym     = {run_len, size};
         end
         send_symbol(sym, 15'($urandom), 1'($urandom));
         k = position_after(k, sym);
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Largest DC, AC magnitude extremes, a run with a value, ZRL and a
      // zero-size symbol with a run standing in for EOB.
      send_symbol(8'h0B, 15'h07FF, 1'b1);
      send_symbol(8'h01, 15'h7FFE, 1'b0);
      send_symbol(8'h0F, 15'h7FFF, 1'b0);
      send_symbol(8'h0F, 15'h0000, 1'b1);
      send_symbol(8'h2F, 15'h4000, 1'b0);
      send_symbol(8'hF0, 15'h7FFF, 1'b0);
      send_symbol(8'h50, 15'h1234, 1'b0);
      // DC with the high nibble set and the most negative size-15 value; a value at the
      // last position ends the block.
      send_symbol(8'hFF, 15'h0000, 1'b0);
      send_symbol(8'hF0, 15'h0000, 1'b0);
      send_symbol(8'hF0, 15'h0000, 1'b0);
      send_symbol(8'hF0, 15'h0000, 1'b0);
      send_symbol(8'hE1, 15'h0001, 1'b0);
      // ZRL clipped at the last position.
      send_symbol(8'h00, 15'h7FFF, 1'b1);
      send_symbol(8'hF0, 15'h0000, 1'b0);
      send_symbol(8'hF0, 15'h0000, 1'b0);
      send_symbol(8'hF0, 15'h0000, 1'b0);
      send_symbol(8'hF0, 15'h0000, 1'b0);
      // A run past the end of the block, then DC keeps the old predictor.
      send_symbol(8'h03, 15'h0005, 1'b0);
      send_symbol(8'hF0, 15'h0000, 1'b0);
      send_symbol(8'hF0, 15'h0000, 1'b0);
      send_symbol(8'hF0, 15'h0000, 1'b0);
      send_symbol(8'hF1, 15'h0001, 1'b0);
      send_symbol(8'h0C, 15'h0800, 1'b0);
      // EOB straight after DC fills the whole block.
      send_symbol(8'h00, 15'h7FFF, 1'b1);

      symbols_sent = 0;
      req_gaps     = 1'b1;
      rsp_stalls   = 1'b1;
      hold_request = 1'b1;
      while (symbols_sent < RANDOM_SYMBOLS) begin
         // A stretch in the middle runs without any idling.
         req_gaps   = !(symbols_sent > 170 && symbols_sent < 280);
         rsp_stalls = req_gaps;
         send_random_block();
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      rsp_stalls = 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("jpeg_block_coefficient_decoder_tb: PASS");
      end else begin
         $display("jpeg_block_coefficient_decoder_tb: FAIL");
      end
      $finish;
   end

endmodule
